// ===== src/rpr_pkg.sv =====
// Shared constants and elaboration-time helpers for the rational polyphase resampler.
// Holds default filter parameters and the sine and window helpers for the coefficient table.
// No dependencies.
`default_nettype none

package rpr_pkg;

	// default configuration of the resampler
	localparam int DEF_UP_FACTOR   = 80;
	localparam int DEF_DOWN_FACTOR = 441;
	localparam int DEF_TAPS        = 1025;
	localparam int DEF_COEF_BITS   = 18;

	// pcm sample format
	localparam int SAMPLE_W = 16;
	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7fff;
	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

	// pi in q30
	localparam longint unsigned PI_Q30 = 64'd3373259426;

	// sin(th) in q30 for a first-quadrant angle, taylor series to the 15th power,
	// products truncated, sign applied last
	function automatic longint sin_series(input longint unsigned th, input bit neg);
		longint unsigned th2;
		longint unsigned term;
		longint          acc;
		th2  = (th * th) >> 30;
		term = th;
		acc  = $signed(th);
		term = ((term * th2) >> 30) / 64'd6;
		acc  = acc - $signed(term);
		term = ((term * th2) >> 30) / 64'd20;
		acc  = acc + $signed(term);
		term = ((term * th2) >> 30) / 64'd42;
		acc  = acc - $signed(term);
		term = ((term * th2) >> 30) / 64'd72;
		acc  = acc + $signed(term);
		term = ((term * th2) >> 30) / 64'd110;
		acc  = acc - $signed(term);
		term = ((term * th2) >> 30) / 64'd156;
		acc  = acc + $signed(term);
		term = ((term * th2) >> 30) / 64'd210;
		acc  = acc - $signed(term);
		return neg ? -acc : acc;
	endfunction

	// hamming window in q30 from the q30 cosine, truncated toward zero, floored at zero
	function automatic longint hamming_q30(input longint c);
		longint w;
		w = (longint'(54) * (longint'(1) <<< 30) - longint'(46) * c) / 64'sd100;
		if (w < 0) begin
			w = 0;
		end
		return w;
	endfunction

endpackage

`default_nettype wire

// ===== src/rational_polyphase_resampler_unit.sv =====
// Stereo rational polyphase resampler (up/down, windowed sinc fir).
// Frame history in a synchronous ring memory, coefficients in a synchronous rom.
// Depends on rpr_pkg.
//
// Usage: stereo pcm frames enter on the in channel (in_valid/in_ready, left_in,
// right_in); resampled frames leave on the out channel (out_valid/out_ready,
// left_out, right_out). Each input item yields zero or one output item.
// An item that yields no output leaves the sequencer idle and the next can follow
// at once. An item that yields an output runs one multiply-accumulate per
// stored frame of its filter phase, both channels side by side: N reads of
// the history memory and coefficient rom (N = ceil(TAPS/UP_FACTOR) at most,
// 13 by default); the read and multiply stages then drain, and the sums are
// rounded and saturated into the output register: the output item turns valid
// in the same cycle that the input turns ready again. No input item is taken
// before then, and a finished result first waits for a free output register.
// When UP_FACTOR exceeds DOWN_FACTOR the phase update adds DOWN_FACTOR once
// per cycle until the phase reaches UP_FACTOR, which can hold the item longer.
// The output register holds a finished item while the receiver stalls; a
// later result waits for it. Reset clears the phase, the ring pointer and the
// fill count, so history slots never written since reset read as zero.
`default_nettype none

module rational_polyphase_resampler_unit #(
	parameter int UP_FACTOR   = rpr_pkg::DEF_UP_FACTOR,
	parameter int DOWN_FACTOR = rpr_pkg::DEF_DOWN_FACTOR,
	parameter int TAPS        = rpr_pkg::DEF_TAPS,
	parameter int COEF_BITS   = rpr_pkg::DEF_COEF_BITS
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 in_valid,
	output logic                                      in_ready,
	input  wire logic signed [rpr_pkg::SAMPLE_W-1:0]  left_in,
	input  wire logic signed [rpr_pkg::SAMPLE_W-1:0]  right_in,
	output logic                                      out_valid,
	input  wire logic                                 out_ready,
	output logic signed [rpr_pkg::SAMPLE_W-1:0]       left_out,
	output logic signed [rpr_pkg::SAMPLE_W-1:0]       right_out
);

	localparam int SW         = rpr_pkg::SAMPLE_W;
	localparam int HIST_DEPTH = (TAPS + UP_FACTOR - 1) / UP_FACTOR;
	localparam int HP_W       = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
	localparam int CNT_W      = $clog2(HIST_DEPTH + 1);
	localparam int TAP_W      = $clog2(TAPS + UP_FACTOR);
	localparam int TAP_IW     = $clog2(TAPS);
	localparam int PH_W       = $clog2(UP_FACTOR + DOWN_FACTOR);
	localparam int FRAC_W     = COEF_BITS - 1;
	localparam int PROD_W     = SW + COEF_BITS;
	localparam int ACC_W      = PROD_W + CNT_W;

	// coefficient table geometry
	localparam longint unsigned CENTRE  = 64'((TAPS - 1) / 2);
	localparam longint unsigned COS_DEN = 64'(2 * (TAPS - 1));
	localparam longint unsigned SNC_DEN = 64'(DOWN_FACTOR);

	localparam logic signed [ACC_W-1:0] RND_BIAS = ACC_W'((64'd1 << FRAC_W) - 64'd1);

	// sequencer states
	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_MAC   = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;

	// round toward zero after dropping the fraction bits, then saturate
	function automatic logic signed [SW-1:0] finish_sample(input logic signed [ACC_W-1:0] acc);
		logic signed [ACC_W-1:0] biased;
		logic signed [ACC_W-1:0] quo;
		biased = acc + (acc[ACC_W-1] ? RND_BIAS : '0);
		quo    = biased >>> FRAC_W;
		if (quo > ACC_W'(rpr_pkg::SAMPLE_MAX)) begin
			return rpr_pkg::SAMPLE_MAX;
		end else if (quo < ACC_W'(rpr_pkg::SAMPLE_MIN)) begin
			return rpr_pkg::SAMPLE_MIN;
		end else begin
			return $signed(quo[SW-1:0]);
		end
	endfunction

	// coefficient rom contents, computed at elaboration
	logic signed [COEF_BITS-1:0] coef_rom [TAPS];

	for (genvar n = 0; n < TAPS; n++) begin : g_coef
		// window cosine, angle folded into the first quadrant
		localparam longint unsigned C_T0  = (64'(4 * n) + 64'(TAPS - 1)) % (64'd2 * COS_DEN);
		localparam bit              C_NEG = (C_T0 >= COS_DEN);
		localparam longint unsigned C_T1  = C_NEG ? C_T0 - COS_DEN : C_T0;
		localparam longint unsigned C_T2  = (64'd2 * C_T1 > COS_DEN) ? COS_DEN - C_T1 : C_T1;
		localparam longint unsigned C_TH  = rpr_pkg::PI_Q30 * C_T2 / COS_DEN;
		localparam longint WIN = rpr_pkg::hamming_q30(rpr_pkg::sin_series(C_TH, C_NEG));
		// sinc at distance from the centre tap
		localparam longint unsigned DIST_X = (64'(n) > CENTRE) ? 64'(n) - CENTRE
			: CENTRE - 64'(n);
		localparam longint unsigned S_T0  = DIST_X % (64'd2 * SNC_DEN);
		localparam bit              S_NEG = (S_T0 >= SNC_DEN);
		localparam longint unsigned S_T1  = S_NEG ? S_T0 - SNC_DEN : S_T0;
		localparam longint unsigned S_T2  = (64'd2 * S_T1 > SNC_DEN) ? SNC_DEN - S_T1 : S_T1;
		localparam longint unsigned S_TH  = rpr_pkg::PI_Q30 * S_T2 / SNC_DEN;
		localparam longint          SNC_VAL = rpr_pkg::sin_series(S_TH, S_NEG);
		localparam bit              NEG     = (DIST_X != 0) && (SNC_VAL < 0);
		localparam longint unsigned SNC_MAG = (SNC_VAL < 0) ? 64'(-SNC_VAL) : 64'(SNC_VAL);
		// scaled tap, rounded half up on the magnitude and clamped
		localparam longint unsigned NUM = (DIST_X == 0)
			? 64'(WIN) * 64'(UP_FACTOR) * (64'd1 << FRAC_W)
			: ((SNC_MAG * 64'(WIN)) >> 30) * 64'(UP_FACTOR) * (64'd1 << FRAC_W);
		localparam longint unsigned DEN = (DIST_X == 0) ? (SNC_DEN << 30)
			: rpr_pkg::PI_Q30 * DIST_X;
		localparam longint unsigned MAG   = (NUM + DEN / 64'd2) / DEN;
		localparam longint unsigned LIM   = NEG ? (64'd1 << FRAC_W) : ((64'd1 << FRAC_W) - 64'd1);
		localparam longint unsigned MAG_C = (MAG > LIM) ? LIM : MAG;
		localparam logic [63:0]     COEF_VAL = NEG ? -MAG_C : MAG_C;
		assign coef_rom[n] = $signed(COEF_VAL[COEF_BITS-1:0]);
	end

	// frame history ring, left in the upper half
	logic [2*SW-1:0] hist_mem [HIST_DEPTH];

	logic [1:0]        state_q;
	logic [HP_W-1:0]   ptr_q;
	logic [HP_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]  fill_q;
	logic [CNT_W-1:0]  j_q;
	logic [TAP_W-1:0]  tap_q;
	logic [PH_W-1:0]   phase_q;
	logic              rd_v_s1;
	logic              mul_v_s2;
	logic [2*SW-1:0]   hist_rd_s1;
	logic              hist_ok_s1;
	logic signed [COEF_BITS-1:0] coef_s1;
	logic signed [PROD_W-1:0]    prod_l_s2;
	logic signed [PROD_W-1:0]    prod_r_s2;
	logic signed [ACC_W-1:0]     acc_l_q;
	logic signed [ACC_W-1:0]     acc_r_q;
	logic              out_valid_q;
	logic signed [SW-1:0] left_out_q;
	logic signed [SW-1:0] right_out_q;

	logic              in_fire;
	logic              due;
	logic              issue;
	logic              phase_low;
	logic              done;
	logic signed [SW-1:0] smp_l;
	logic signed [SW-1:0] smp_r;

	// handshake and sequencing conditions
	assign in_ready  = (state_q == ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign phase_low = (phase_q < PH_W'(UP_FACTOR));
	assign due       = phase_low;
	assign issue     = (state_q == ST_MAC) && (tap_q < TAP_W'(TAPS));
	assign done      = (state_q == ST_DRAIN) && !rd_v_s1 && !mul_v_s2 && !phase_low
		&& (!out_valid_q || out_ready);

	assign out_valid = out_valid_q;
	assign left_out  = left_out_q;
	assign right_out = right_out_q;

	// samples older than the fill count read as zero
	assign smp_l = hist_ok_s1 ? $signed(hist_rd_s1[2*SW-1:SW]) : '0;
	assign smp_r = hist_ok_s1 ? $signed(hist_rd_s1[SW-1:0]) : '0;

	// history write on accept, history and rom read per tap
	always_ff @(posedge clk) begin
		if (in_fire) begin
			hist_mem[ptr_q] <= {left_in, right_in};
		end
		if (issue) begin
			hist_rd_s1 <= hist_mem[rd_ptr_q];
			coef_s1    <= coef_rom[tap_q[TAP_IW-1:0]];
			hist_ok_s1 <= (j_q < fill_q);
		end
	end

	// multiply stage and accumulators
	always_ff @(posedge clk) begin
		if (rd_v_s1) begin
			prod_l_s2 <= smp_l * coef_s1;
			prod_r_s2 <= smp_r * coef_s1;
		end
		if (in_fire) begin
			acc_l_q <= '0;
			acc_r_q <= '0;
		end else if (mul_v_s2) begin
			acc_l_q <= acc_l_q + ACC_W'(prod_l_s2);
			acc_r_q <= acc_r_q + ACC_W'(prod_r_s2);
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (done) begin
			left_out_q  <= finish_sample(acc_l_q);
			right_out_q <= finish_sample(acc_r_q);
		end
	end

	// sequencer, ring pointers, phase residue and pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ptr_q       <= '0;
			rd_ptr_q    <= '0;
			fill_q      <= '0;
			j_q         <= '0;
			tap_q       <= '0;
			phase_q     <= '0;
			rd_v_s1     <= 1'b0;
			mul_v_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_v_s1  <= issue;
			mul_v_s2 <= rd_v_s1;

			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (done) begin
				out_valid_q <= 1'b1;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						ptr_q    <= (ptr_q == HP_W'(HIST_DEPTH - 1)) ? '0 : ptr_q + 1'b1;
						rd_ptr_q <= ptr_q;
						if (fill_q != CNT_W'(HIST_DEPTH)) begin
							fill_q <= fill_q + 1'b1;
						end
						j_q   <= '0;
						tap_q <= TAP_W'(phase_q);
						if (due) begin
							phase_q <= phase_q + PH_W'(DOWN_FACTOR);
							state_q <= ST_MAC;
						end else begin
							phase_q <= phase_q - PH_W'(UP_FACTOR);
						end
					end
				end
				ST_MAC: begin
					if (phase_low) begin
						phase_q <= phase_q + PH_W'(DOWN_FACTOR);
					end
					if (issue) begin
						tap_q    <= tap_q + TAP_W'(UP_FACTOR);
						j_q      <= j_q + 1'b1;
						rd_ptr_q <= (rd_ptr_q == '0) ? HP_W'(HIST_DEPTH - 1) : rd_ptr_q - 1'b1;
					end else begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (phase_low) begin
						phase_q <= phase_q + PH_W'(DOWN_FACTOR);
					end
					if (done) begin
						phase_q <= phase_q - PH_W'(UP_FACTOR);
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== verif/rational_polyphase_resampler_unit_tb.sv =====
// Self-checking testbench for the stereo rational polyphase resampler.
// Predicts every output frame from its own coefficient table and delay line.
// Depends on rpr_pkg and rational_polyphase_resampler_unit.
`timescale 1ns / 100ps

module rational_polyphase_resampler_unit_tb;

	localparam int UP     = rpr_pkg::DEF_UP_FACTOR;
	localparam int DOWN   = rpr_pkg::DEF_DOWN_FACTOR;
	localparam int TAPS   = rpr_pkg::DEF_TAPS;
	localparam int FRAC   = rpr_pkg::DEF_COEF_BITS - 1;
	localparam int DEPTH  = (TAPS + UP - 1) / UP;
	localparam int CENTRE = (TAPS - 1) / 2;
	localparam int PHASE_ITEMS = 338;

	typedef longint unsigned u64_t;
	typedef logic signed [rpr_pkg::SAMPLE_W-1:0] pcm_t;
	typedef struct packed {
		pcm_t left;
		pcm_t right;
	} frame_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	pcm_t left_in = '0;
	pcm_t right_in = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	pcm_t left_out;
	pcm_t right_out;

	// predictor state
	int   coef_table [TAPS];
	pcm_t left_hist [DEPTH];
	pcm_t right_hist [DEPTH];
	int   hist_slot = 0;
	int   residue = 0;

	frame_t pending_frames [$];
	int     idle_pct = 0;
	int     stall_pct = 0;
	int     errors = 0;
	int     items_sent = 0;
	int     frames_seen = 0;

	rational_polyphase_resampler_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.left_in   (left_in),
		.right_in  (right_in),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.left_out  (left_out),
		.right_out (right_out)
	);

	always #5 clk = ~clk;

	// watchdog
	initial begin
		#5000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// sin(pi*num/den) in q30, odd series to the 15th power, truncating each product
	function automatic longint sine_q30(input u64_t num, input u64_t den);
		u64_t   ang;
		u64_t   th;
		u64_t   th_sq;
		u64_t   term;
		longint acc;
		bit     flip;
		int     k;
		ang  = num % (2 * den);
		flip = 1'b0;
		if (ang >= den) begin
			ang  = ang - den;
			flip = 1'b1;
		end
		if (2 * ang > den) begin
			ang = den - ang;
		end
		th    = rpr_pkg::PI_Q30 * ang / den;
		th_sq = (th * th) >> 30;
		term  = th;
		acc   = longint'(th);
		for (k = 1; k <= 7; k++) begin
			term = ((term * th_sq) >> 30) / (u64_t'(2 * k) * u64_t'(2 * k + 1));
			if (k % 2 == 1) begin
				acc = acc - longint'(term);
			end else begin
				acc = acc + longint'(term);
			end
		end
		return flip ? -acc : acc;
	endfunction

	// hamming-windowed sinc tap, gain up, cutoff pi/down, rounded half up and clamped
	function automatic longint window_tap(input int n);
		longint cosv;
		longint win;
		longint sv;
		u64_t   num;
		u64_t   den;
		u64_t   mag;
		u64_t   lim;
		u64_t   sm;
		u64_t   prod;
		int     offs;
		bit     neg;
		neg  = 1'b0;
		cosv = sine_q30(4 * u64_t'(n) + u64_t'(TAPS - 1), 2 * u64_t'(TAPS - 1));
		win  = (64'sd54 * 64'sd1073741824 - 64'sd46 * cosv) / 64'sd100;
		if (win < 0) begin
			win = 0;
		end
		if (n == CENTRE) begin
			num = u64_t'(win) * u64_t'(UP) * (u64_t'(1) << FRAC);
			den = u64_t'(DOWN) << 30;
		end else begin
			offs = (n > CENTRE) ? n - CENTRE : CENTRE - n;
			sv   = sine_q30(u64_t'(offs), u64_t'(DOWN));
			if (sv < 0) begin
				neg = 1'b1;
				sm  = u64_t'(-sv);
			end else begin
				sm  = u64_t'(sv);
			end
			prod = (sm * u64_t'(win)) >> 30;
			num  = prod * u64_t'(UP) * (u64_t'(1) << FRAC);
			den  = rpr_pkg::PI_Q30 * u64_t'(offs);
		end
		mag = (num + den / 2) / den;
		lim = neg ? (u64_t'(1) << FRAC) : ((u64_t'(1) << FRAC) - 1);
		if (mag > lim) begin
			mag = lim;
		end
		return neg ? -longint'(mag) : longint'(mag);
	endfunction

	// drop fraction bits toward zero, then clamp to pcm range
	function automatic pcm_t round_sat(input longint acc);
		longint q;
		q = acc / (longint'(1) << FRAC);
		if (q > longint'(rpr_pkg::SAMPLE_MAX)) begin
			q = longint'(rpr_pkg::SAMPLE_MAX);
		end
		if (q < longint'(rpr_pkg::SAMPLE_MIN)) begin
			q = longint'(rpr_pkg::SAMPLE_MIN);
		end
		return pcm_t'(q);
	endfunction

	// store one frame; when an output falls due, form it from the stored frames
	function automatic bit resample_frame(input pcm_t l, input pcm_t r,
			output pcm_t lo, output pcm_t ro);
		longint accl;
		longint accr;
		int     j;
		int     tap;
		int     idx;
		int     slot;
		slot = hist_slot;
		left_hist[slot]  = l;
		right_hist[slot] = r;
		lo = '0;
		ro = '0;
		resample_frame = 1'b0;
		if (residue < UP) begin
			accl = 0;
			accr = 0;
			for (j = 0; j < DEPTH; j++) begin
				tap = residue + j * UP;
				if (tap < TAPS) begin
					idx  = (slot + DEPTH - j) % DEPTH;
					accl = accl + longint'(left_hist[idx]) * longint'(coef_table[tap]);
					accr = accr + longint'(right_hist[idx]) * longint'(coef_table[tap]);
				end
			end
			lo = round_sat(accl);
			ro = round_sat(accr);
			resample_frame = 1'b1;
			residue = residue + DOWN;
			while (residue < UP) begin
				residue = residue + DOWN;
			end
		end
		residue   = residue - UP;
		hist_slot = (slot + 1) % DEPTH;
	endfunction

	// receiver back-pressure
	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= stall_pct);
	end

	// output checker
	always @(posedge clk) begin
		frame_t exp_f;
		if (arst_n && out_valid && out_ready) begin
			frames_seen++;
			if (pending_frames.size() == 0) begin
				errors++;
				$display("%0t: output item with none expected, got %0d / %0d",
					$time, left_out, right_out);
			end else begin
				exp_f = pending_frames.pop_front();
				if (left_out !== exp_f.left) begin
					errors++;
					$display("%0t: left_out mismatch, expected %0d, got %0d",
						$time, $signed(exp_f.left), left_out);
				end
				if (right_out !== exp_f.right) begin
					errors++;
					$display("%0t: right_out mismatch, expected %0d, got %0d",
						$time, $signed(exp_f.right), right_out);
				end
			end
		end
	end

	// offer one frame, with random idle cycles ahead of it, and wait for acceptance
	task automatic send_frame(input pcm_t l, input pcm_t r);
		pcm_t   lo;
		pcm_t   ro;
		frame_t f;
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		left_in  <= l;
		right_in <= r;
		do @(posedge clk); while (!in_ready);
		items_sent++;
		if (resample_frame(l, r, lo, ro)) begin
			f.left  = lo;
			f.right = ro;
			pending_frames.push_back(f);
		end
	endtask

	// hold off the sender until every expected output item has come
	task automatic wait_for_drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_frames.size() != 0) begin
			@(posedge clk);
		end
	endtask

	function automatic pcm_t random_sample();
		case ($urandom_range(9))
			5: return rpr_pkg::SAMPLE_MAX;
			6: return rpr_pkg::SAMPLE_MIN;
			7: return $urandom_range(1) ? pcm_t'(-1) : pcm_t'(0);
			8, 9: return pcm_t'(int'($urandom_range(512)) - 256);
			default: return pcm_t'($urandom);
		endcase
	endfunction

	// impulse right after reset: earlier frames must read as zero
	task automatic test_start_of_stream();
		int i;
		send_frame(rpr_pkg::SAMPLE_MAX, rpr_pkg::SAMPLE_MIN);
		for (i = 0; i < 5; i++) begin
			send_frame('0, '0);
		end
		wait_for_drain();
	endtask

	// full-scale constant input, filling the whole delay line
	task automatic test_full_scale();
		int i;
		stall_pct = 50;
		for (i = 0; i < 14; i++) begin
			send_frame(rpr_pkg::SAMPLE_MAX, rpr_pkg::SAMPLE_MIN);
		end
		wait_for_drain();
		stall_pct = 0;
	endtask

	// samples follow the sign of the tap they meet, pushing sums toward saturation
	task automatic test_sign_matched();
		int   i;
		int   tap;
		pcm_t l;
		for (i = 0; i < 6; i++) begin
			tap = (residue % UP) + (residue / UP) * UP;
			l = (tap >= TAPS || coef_table[tap] >= 0) ? rpr_pkg::SAMPLE_MAX
				: rpr_pkg::SAMPLE_MIN;
			send_frame(l, (l == rpr_pkg::SAMPLE_MAX) ? rpr_pkg::SAMPLE_MIN
				: rpr_pkg::SAMPLE_MAX);
		end
		wait_for_drain();
	endtask

	// random frames under one traffic pattern
	task automatic test_traffic(input int send_idle, input int recv_stall, input int count);
		int i;
		idle_pct  = send_idle;
		stall_pct = recv_stall;
		for (i = 0; i < count; i++) begin
			send_frame(random_sample(), random_sample());
		end
		wait_for_drain();
	endtask

	initial begin
		int n;
		for (n = 0; n < TAPS; n++) begin
			coef_table[n] = int'(window_tap(n));
		end
		for (n = 0; n < DEPTH; n++) begin
			left_hist[n]  = '0;
			right_hist[n] = '0;
		end
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_start_of_stream();
		test_full_scale();
		test_sign_matched();
		test_traffic(0, 0, PHASE_ITEMS);
		test_traffic(70, 0, PHASE_ITEMS);
		test_traffic(0, 70, PHASE_ITEMS);
		test_traffic(34, 34, PHASE_ITEMS);

		// let any stray output surface
		repeat (40) @(posedge clk);
		if (pending_frames.size() != 0) begin
			errors++;
			$display("%0t: %0d output items never arrived", $time, pending_frames.size());
		end
		$display("covered impulse, full-scale and sign-matched frames, then random traffic");
		$display("%0d input items sent, %0d output items checked", items_sent, frames_seen);
		if (errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
